// File: sv/fsnq_pkg.sv
// Shared types and codes for the frequency sorted node queue.
// No dependencies.
package fsnq_pkg;

  // request codes on req_type_i
  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctl_t;

endpackage

// File: sv/fsnq_cell.sv
// One queue slot: holds an entry, compares it with the insert key and
// loads from the new word or a neighbor. Depends on fsnq_pkg.
module fsnq_cell #(
  parameter int FREQ_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fsnq_pkg::cell_ctl_t   ctl_i,
  input  logic [FREQ_BITS-1:0]  key_i,
  input  logic                  new_leaf_i,
  input  logic [8:0]            new_item_i,
  input  logic [FREQ_BITS-1:0]  left_freq_i,
  input  logic                  left_leaf_i,
  input  logic [8:0]            left_item_i,
  input  logic [FREQ_BITS-1:0]  right_freq_i,
  input  logic                  right_leaf_i,
  input  logic [8:0]            right_item_i,
  output logic [FREQ_BITS-1:0]  freq_o,
  output logic                  leaf_o,
  output logic [8:0]            item_o,
  output logic                  hit_o
);

  logic [FREQ_BITS-1:0] freq_q;
  logic                 leaf_q;
  logic [8:0]           item_q;
  logic                 hit_q;

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      fsnq_pkg::CELL_LOAD: begin
        freq_q <= key_i;
        leaf_q <= new_leaf_i;
        item_q <= new_item_i;
      end
      fsnq_pkg::CELL_FROM_LEFT: begin
        freq_q <= left_freq_i;
        leaf_q <= left_leaf_i;
        item_q <= left_item_i;
      end
      fsnq_pkg::CELL_FROM_RIGHT: begin
        freq_q <= right_freq_i;
        leaf_q <= right_leaf_i;
        item_q <= right_item_i;
      end
      default: begin
      end
    endcase
  end

  // insert goes ahead of an entry with frequency >= key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      hit_q <= (key_i <= freq_q);
    end
  end

  assign freq_o = freq_q;
  assign leaf_o = leaf_q;
  assign item_o = item_q;
  assign hit_o  = hit_q;

endmodule

// File: sv/fsnq_prefix.sv
// Log-depth prefix OR over the cell hit bits: which cells lie behind
// the insert point, and whether any cell hit. No package dependency.
module fsnq_prefix #(
  parameter int N = 256
) (
  input  logic [N-1:0] hit_i,
  output logic [N-1:0] before_o,
  output logic         any_o
);

  localparam int LV = $clog2(N);

  logic [N-1:0] lvl [0:LV];

  assign lvl[0] = hit_i;

  for (genvar k = 0; k < LV; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign before_o = {lvl[LV][N-2:0], 1'b0};
  assign any_o    = lvl[LV][N-1];

endmodule

// File: sv/frequency_sorted_node_queue.sv
// Frequency sorted node queue: a row of DEPTH cells, all shifting at once.
// Append, dequeue and clear finish in their accept cycle; ordered insert adds a
// second state (a compare in every cell, then the prefix OR over the hit bits
// and the shift). The result is registered and shows in the cycle after the last
// work cycle. Next request is taken in S_IDLE once the output register is free.
// Reset clears the count and control; cell contents are undefined until written.
module frequency_sorted_node_queue #(
  parameter int DEPTH     = 256,
  parameter int FREQ_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [23:0] frequency_i,
  input  logic        is_leaf_i,
  input  logic [8:0]  item_id_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [1:0]  status_o,
  output logic        out_valid_o,
  output logic [23:0] out_frequency_o,
  output logic        out_is_leaf_o,
  output logic [8:0]  out_item_o,
  output logic        first_entry_o,
  output logic [8:0]  entry_count_o
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_CMP
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [FREQ_BITS-1:0]  key_q;
  logic                  leaf_q;
  logic [8:0]            item_q;

  logic                  res_valid_q;
  logic [1:0]            status_q, status_d;
  logic                  ov_q, ov_d;
  logic [23:0]           of_q, of_d;
  logic                  ol_q, ol_d;
  logic [8:0]            oi_q, oi_d;
  logic                  fe_q, fe_d;
  logic [8:0]            cnt_q, cnt_d;
  logic                  res_load;

  logic                  accept;
  logic [FREQ_BITS+23:0] in_ext;
  logic [FREQ_BITS-1:0]  in_key;
  logic [FREQ_BITS-1:0]  new_key;
  logic                  new_leaf;
  logic [8:0]            new_item;
  logic [FREQ_BITS+23:0] head_ext;
  logic [CW+8:0]         cnt_ext;

  fsnq_pkg::cell_ctl_t   ctl [DEPTH];
  logic [FREQ_BITS-1:0]  c_freq [DEPTH];
  logic                  c_leaf [DEPTH];
  logic [8:0]            c_item [DEPTH];
  logic [DEPTH-1:0]      c_hit;
  logic [DEPTH-1:0]      hit_m;
  logic [DEPTH-1:0]      behind;
  logic                  any_hit;

  // frequency kept to FREQ_BITS bits, zero-extended when wider
  assign in_ext   = {{FREQ_BITS{1'b0}}, frequency_i};
  assign in_key   = in_ext[FREQ_BITS-1:0];
  assign head_ext = {24'd0, c_freq[0]};
  assign cnt_ext  = {9'd0, count_d};

  assign new_key  = (state_q == S_CMP) ? key_q  : in_key;
  assign new_leaf = (state_q == S_CMP) ? leaf_q : is_leaf_i;
  assign new_item = (state_q == S_CMP) ? item_q : item_id_i;

  assign req_stall_o = (state_q != S_IDLE) || (res_valid_q && res_stall_i);
  assign accept      = req_valid_i && !req_stall_o;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [FREQ_BITS-1:0] lf, rf;
    logic                 ll, rl;
    logic [8:0]           li, ri;

    if (i == 0) begin : g_head
      assign lf = '0;
      assign ll = 1'b0;
      assign li = '0;
    end else begin : g_mid
      assign lf = c_freq[i-1];
      assign ll = c_leaf[i-1];
      assign li = c_item[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rf = '0;
      assign rl = 1'b0;
      assign ri = '0;
    end else begin : g_body
      assign rf = c_freq[i+1];
      assign rl = c_leaf[i+1];
      assign ri = c_item[i+1];
    end

    fsnq_cell #(
      .FREQ_BITS(FREQ_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl[i]),
      .key_i        (new_key),
      .new_leaf_i   (new_leaf),
      .new_item_i   (new_item),
      .left_freq_i  (lf),
      .left_leaf_i  (ll),
      .left_item_i  (li),
      .right_freq_i (rf),
      .right_leaf_i (rl),
      .right_item_i (ri),
      .freq_o       (c_freq[i]),
      .leaf_o       (c_leaf[i]),
      .item_o       (c_item[i]),
      .hit_o        (c_hit[i])
    );

    // only slots in use take part in the search
    assign hit_m[i] = c_hit[i] && (CW'(i) < count_q);
  end

  fsnq_prefix #(
    .N(DEPTH)
  ) u_prefix (
    .hit_i    (hit_m),
    .before_o (behind),
    .any_o    (any_hit)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    res_load = 1'b0;
    status_d = fsnq_pkg::ST_DONE;
    ov_d     = 1'b0;
    of_d     = '0;
    ol_d     = 1'b0;
    oi_d     = '0;
    fe_d     = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].op     = fsnq_pkg::CELL_HOLD;
      ctl[i].cmp_en = 1'b0;
    end

    if (state_q == S_CMP) begin
      if (!(res_valid_q && res_stall_i)) begin
        // cells behind the insert point shift toward the tail
        for (int i = 0; i < DEPTH; i++) begin
          if (behind[i]) begin
            ctl[i].op = fsnq_pkg::CELL_FROM_LEFT;
          end else if (hit_m[i] || (!any_hit && count_q == CW'(i))) begin
            ctl[i].op = fsnq_pkg::CELL_LOAD;
          end
        end
        count_d  = count_q + 1'b1;
        fe_d     = (count_q == '0);
        res_load = 1'b1;
        state_d  = S_IDLE;
      end
    end else if (accept) begin
      case (req_type_i)
        fsnq_pkg::REQ_APPEND: begin
          res_load = 1'b1;
          if (count_q == CW'(DEPTH)) begin
            status_d = fsnq_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (count_q == CW'(i)) begin
                ctl[i].op = fsnq_pkg::CELL_LOAD;
              end
            end
            count_d = count_q + 1'b1;
          end
        end
        fsnq_pkg::REQ_INSERT: begin
          if (count_q == CW'(DEPTH)) begin
            status_d = fsnq_pkg::ST_FULL;
            res_load = 1'b1;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].cmp_en = 1'b1;
            end
            state_d = S_CMP;
          end
        end
        fsnq_pkg::REQ_DEQUEUE: begin
          res_load = 1'b1;
          if (count_q == '0) begin
            status_d = fsnq_pkg::ST_EMPTY;
          end else begin
            ov_d = 1'b1;
            of_d = head_ext[23:0];
            ol_d = c_leaf[0];
            oi_d = c_item[0];
            for (int i = 0; i < DEPTH; i++) begin
              ctl[i].op = fsnq_pkg::CELL_FROM_RIGHT;
            end
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          res_load = 1'b1;
          count_d  = '0;
        end
      endcase
    end
    cnt_d = cnt_ext[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      key_q       <= '0;
      leaf_q      <= 1'b0;
      item_q      <= '0;
      res_valid_q <= 1'b0;
      status_q    <= fsnq_pkg::ST_DONE;
      ov_q        <= 1'b0;
      of_q        <= '0;
      ol_q        <= 1'b0;
      oi_q        <= '0;
      fe_q        <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (accept) begin
        key_q  <= in_key;
        leaf_q <= is_leaf_i;
        item_q <= item_id_i;
      end
      res_valid_q <= res_load || (res_valid_q && res_stall_i);
      if (res_load) begin
        status_q    <= status_d;
        ov_q        <= ov_d;
        of_q        <= of_d;
        ol_q        <= ol_d;
        oi_q        <= oi_d;
        fe_q        <= fe_d;
        cnt_q       <= cnt_d;
      end
    end
  end

  assign res_valid_o     = res_valid_q;
  assign status_o        = status_q;
  assign out_valid_o     = ov_q;
  assign out_frequency_o = of_q;
  assign out_is_leaf_o   = ol_q;
  assign out_item_o      = oi_q;
  assign first_entry_o   = fe_q;
  assign entry_count_o   = cnt_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_cmp_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> count_q != CW'(DEPTH))
    else $error("insert compare started on a full queue");

  a_cmp_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP && !(res_valid_q && res_stall_i)
      |=> state_q == S_IDLE && res_valid_q)
    else $error("insert did not finish with a result word");

  a_deq_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == fsnq_pkg::ST_DONE)
    else $error("dequeued entry with error status");
`endif

endmodule

// File: test/testbench.sv
// Self-checking bench for frequency_sorted_node_queue: a queue-based predictor,
// a driver and a monitor on the valid/stall channels, and Huffman-style stimulus.
// Depends on fsnq_pkg and the frequency_sorted_node_queue RTL.
module testbench;

  localparam int QUEUE_DEPTH = 256;
  localparam int PLAN_ITEMS  = 1250;

  typedef struct {
    fsnq_pkg::req_e kind;
    logic [23:0]    freq;
    logic           leaf;
    logic [8:0]     item;
  } req_word_t;

  typedef struct {
    logic [23:0] freq;
    logic        leaf;
    logic [8:0]  item;
  } node_t;

  typedef struct {
    fsnq_pkg::status_e status;
    logic              valid;
    logic [23:0]       freq;
    logic              leaf;
    logic [8:0]        item;
    logic              first;
    logic [8:0]        count;
  } result_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           req_stall_o;
  fsnq_pkg::req_e req_type_i = fsnq_pkg::REQ_APPEND;
  logic [23:0]    frequency_i = '0;
  logic           is_leaf_i = 1'b0;
  logic [8:0]     item_id_i = '0;
  logic           res_valid_o;
  logic           res_stall_i = 1'b0;
  logic [1:0]     status_o;
  logic           out_valid_o;
  logic [23:0]    out_frequency_o;
  logic           out_is_leaf_o;
  logic [8:0]     out_item_o;
  logic           first_entry_o;
  logic [8:0]     entry_count_o;

  frequency_sorted_node_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .req_type_i     (req_type_i),
    .frequency_i    (frequency_i),
    .is_leaf_i      (is_leaf_i),
    .item_id_i      (item_id_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .status_o       (status_o),
    .out_valid_o    (out_valid_o),
    .out_frequency_o(out_frequency_o),
    .out_is_leaf_o  (out_is_leaf_o),
    .out_item_o     (out_item_o),
    .first_entry_o  (first_entry_o),
    .entry_count_o  (entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  req_word_t req_backlog[$];
  result_t   due_results[$];
  node_t     held_nodes[$];   // predicted queue contents, head first
  int        planned = 0;
  int        plan_count = 0;  // queue occupancy as seen by the generator
  int        taken_count = 0;
  int        errors = 0;
  logic      calm;

  // stretch with no idling on either side
  assign calm = (taken_count >= 500) && (taken_count < 800);

  // ---------------------------------------------------------------- predictor
  task automatic predict_queue_result(input req_word_t r);
    result_t res;
    node_t   n;
    int      pos;
    int      i;
    res.status = fsnq_pkg::ST_DONE;
    res.valid  = 1'b0;
    res.freq   = '0;
    res.leaf   = 1'b0;
    res.item   = '0;
    res.first  = 1'b0;
    n.freq = r.freq;
    n.leaf = r.leaf;
    n.item = r.item;
    case (r.kind)
      fsnq_pkg::REQ_APPEND: begin
        if (held_nodes.size() >= QUEUE_DEPTH) res.status = fsnq_pkg::ST_FULL;
        else held_nodes.push_back(n);
      end
      fsnq_pkg::REQ_INSERT: begin
        if (held_nodes.size() >= QUEUE_DEPTH) begin
          res.status = fsnq_pkg::ST_FULL;
        end else begin
          if (held_nodes.size() == 0) res.first = 1'b1;
          pos = held_nodes.size();
          for (i = 0; i < held_nodes.size(); i++) begin
            if (n.freq <= held_nodes[i].freq) begin
              pos = i;
              break;
            end
          end
          held_nodes.insert(pos, n);
        end
      end
      fsnq_pkg::REQ_DEQUEUE: begin
        if (held_nodes.size() == 0) begin
          res.status = fsnq_pkg::ST_EMPTY;
        end else begin
          n = held_nodes.pop_front();
          res.valid = 1'b1;
          res.freq  = n.freq;
          res.leaf  = n.leaf;
          res.item  = n.item;
        end
      end
      default: held_nodes.delete();
    endcase
    res.count = 9'(held_nodes.size());
    due_results.push_back(res);
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic [23:0] rand_freq();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 15));
      1: return 24'($urandom_range(0, 4095));
      2: return 24'($urandom);
      default: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
    endcase
  endfunction

  task automatic push_req(input fsnq_pkg::req_e kind, input logic [23:0] freq,
                          input logic leaf, input logic [8:0] item);
    req_word_t w;
    w.kind = kind;
    w.freq = freq;
    w.leaf = leaf;
    w.item = item;
    req_backlog.push_back(w);
    planned++;
    case (kind)
      fsnq_pkg::REQ_APPEND, fsnq_pkg::REQ_INSERT: if (plan_count < QUEUE_DEPTH) plan_count++;
      fsnq_pkg::REQ_DEQUEUE: if (plan_count > 0) plan_count--;
      default: plan_count = 0;
    endcase
  endtask

  task automatic push_dequeue();
    push_req(fsnq_pkg::REQ_DEQUEUE, 24'($urandom), 1'($urandom), 9'($urandom));
  endtask

  // Sorted leaves, then repeated merge of the two lightest nodes.
  // An abandoned round stops merging part way through.
  task automatic huffman_round(input int leaves, input bit abandon);
    logic [23:0] mirror[$];
    logic [23:0] f, step, a, b, s;
    int          pos, i, k, handle, merges;
    push_req(fsnq_pkg::REQ_CLEAR, 24'($urandom), 1'($urandom), 9'($urandom));
    f = 24'($urandom_range(0, 20));
    for (k = 0; k < leaves; k++) begin
      push_req(fsnq_pkg::REQ_APPEND, f, 1'b1, 9'($urandom_range(0, 255)));
      mirror.push_back(f);
      step = 24'($urandom_range(0, 1 << $urandom_range(0, 20)));
      if (f > 24'hFFFFFF - step) f = 24'hFFFFFF;
      else f = f + step;
    end
    merges = abandon ? $urandom_range(0, leaves - 1) : leaves - 1;
    handle = 256 + $urandom_range(0, 200);
    for (k = 0; k < merges && mirror.size() > 1; k++) begin
      a = mirror.pop_front();
      push_dequeue();
      b = mirror.pop_front();
      push_dequeue();
      s = a + b;  // wraps at 24 bits like the stored key
      pos = mirror.size();
      for (i = 0; i < mirror.size(); i++) begin
        if (s <= mirror[i]) begin
          pos = i;
          break;
        end
      end
      mirror.insert(pos, s);
      push_req(fsnq_pkg::REQ_INSERT, s, 1'b0, 9'(handle));
      handle = (handle == 511) ? 256 : handle + 1;
    end
    if (!abandon) begin
      push_dequeue();
      if ($urandom_range(0, 3) == 0) push_dequeue();
    end
  endtask

  task automatic fill_queue(input bit by_insert);
    int k;
    push_req(fsnq_pkg::REQ_CLEAR, 24'($urandom), 1'($urandom), 9'($urandom));
    while (plan_count < QUEUE_DEPTH)
      push_req(by_insert ? fsnq_pkg::REQ_INSERT : fsnq_pkg::REQ_APPEND, rand_freq(),
               1'($urandom), 9'($urandom));
    for (k = 0; k < 2; k++) begin
      push_req(fsnq_pkg::REQ_APPEND, rand_freq(), 1'($urandom), 9'($urandom));
      push_req(fsnq_pkg::REQ_INSERT, rand_freq(), 1'($urandom), 9'($urandom));
    end
    for (k = $urandom_range(1, 3); k > 0; k--) push_dequeue();
    push_req(fsnq_pkg::REQ_INSERT, rand_freq(), 1'($urandom), 9'($urandom));
    push_req(fsnq_pkg::REQ_CLEAR, 24'($urandom), 1'($urandom), 9'($urandom));
  endtask

  task automatic noise_burst(input int count);
    int k;
    for (k = 0; k < count; k++)
      push_req(fsnq_pkg::req_e'($urandom_range(0, 3)), 24'($urandom), 1'($urandom),
               9'($urandom));
  endtask

  // ---------------------------------------------------------------- driver
  req_word_t offered;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_type_i  <= fsnq_pkg::REQ_APPEND;
      frequency_i <= '0;
      is_leaf_i   <= 1'b0;
      item_id_i   <= '0;
      taken_count <= 0;
    end else begin
      if (req_valid_i && !req_stall_o) begin
        predict_queue_result(offered);
        taken_count <= taken_count + 1;
      end
      // a stalled word stays put; otherwise offer the next one or idle
      if (!req_valid_i || !req_stall_o) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          offered = req_backlog.pop_front();
          req_valid_i <= 1'b1;
          req_type_i  <= offered.kind;
          frequency_i <= offered.freq;
          is_leaf_i   <= offered.leaf;
          item_id_i   <= offered.item;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_left = 0;
  int holds_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
      hold_left   <= 0;
      holds_done  <= 0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      res_stall_i <= 1'b1;
    end else if ((holds_done == 0 && taken_count >= 200) ||
                 (holds_done == 1 && taken_count >= 900)) begin
      // long hold-off so the queue backs up into the request side
      hold_left   <= 80;
      holds_done  <= holds_done + 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result word with none expected, status %0h count %0d",
                 $time, status_o, entry_count_o);
        errors++;
      end else begin
        want_res = due_results.pop_front();
        check_field("status", 32'(want_res.status), 32'(status_o));
        check_field("out_valid", 32'(want_res.valid), 32'(out_valid_o));
        check_field("out_frequency", 32'(want_res.freq), 32'(out_frequency_o));
        check_field("out_is_leaf", 32'(want_res.leaf), 32'(out_is_leaf_o));
        check_field("out_item", 32'(want_res.item), 32'(out_item_o));
        check_field("first_entry", 32'(want_res.first), 32'(first_entry_o));
        check_field("entry_count", 32'(want_res.count), 32'(entry_count_o));
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int  k;
    bit  did_append_fill;
    bit  did_insert_fill;
    did_append_fill = 1'b0;
    did_insert_fill = 1'b0;

    // directed: empty cases, extremes, ordering ties, clear of a loaded queue
    push_req(fsnq_pkg::REQ_DEQUEUE, 24'hFFFFFF, 1'b1, 9'h1FF);
    push_req(fsnq_pkg::REQ_CLEAR, 24'h0, 1'b0, 9'h0);
    push_req(fsnq_pkg::REQ_INSERT, 24'hFFFFFF, 1'b0, 9'h1FF);
    push_req(fsnq_pkg::REQ_INSERT, 24'h000000, 1'b1, 9'h000);
    push_req(fsnq_pkg::REQ_INSERT, 24'hFFFFFF, 1'b1, 9'h155);
    push_req(fsnq_pkg::REQ_APPEND, 24'h000000, 1'b0, 9'h0AA);
    push_req(fsnq_pkg::REQ_INSERT, 24'h800000, 1'b0, 9'h100);
    push_req(fsnq_pkg::REQ_INSERT, 24'h000000, 1'b0, 9'h0FF);
    for (k = 0; k < 7; k++) push_dequeue();
    push_req(fsnq_pkg::REQ_APPEND, 24'h123456, 1'b1, 9'h042);
    push_req(fsnq_pkg::REQ_APPEND, 24'hEDCBA9, 1'b0, 9'h1BD);
    push_req(fsnq_pkg::REQ_CLEAR, 24'hFFFFFF, 1'b1, 9'h1FF);
    push_dequeue();
    push_req(fsnq_pkg::REQ_INSERT, 24'h5A5A5A, 1'b1, 9'h0C3);
    push_req(fsnq_pkg::REQ_APPEND, 24'hA5A5A5, 1'b0, 9'h13C);
    push_req(fsnq_pkg::REQ_CLEAR, 24'h0, 1'b0, 9'h0);

    while (planned < PLAN_ITEMS) begin
      if (!did_append_fill && planned > 300) begin
        fill_queue(1'b0);
        did_append_fill = 1'b1;
      end else if (!did_insert_fill && planned > 700) begin
        fill_queue(1'b1);
        did_insert_fill = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: huffman_round($urandom_range(1, 24), 1'b0);
          12, 13, 14: huffman_round($urandom_range(2, 24), 1'b1);
          default: noise_burst(10);
        endcase
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (taken_count != planned) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("frequency_sorted_node_queue regression: pass");
    end else begin
      $display("frequency_sorted_node_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("frequency_sorted_node_queue regression: fail");
    $finish;
  end

endmodule
